// File: rtl/core/assert_macros.svh
// assertion macros used by blpm_engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define BLPM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define BLPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define BLPM_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define BLPM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/blpm_pkg.sv
// types and constants of the binary trie route table
`default_nettype none

package blpm_pkg;

    localparam int ADDR_W             = 32;
    localparam int TOP_BIT            = ADDR_W - 1;
    localparam int PLEN_W             = 6;
    localparam int HOP_W              = 32;
    localparam int IFC_W              = 8;
    localparam int NODE_POOL_SIZE_DEF = 4096;
    localparam int INTERFACE_BITS_DEF = 8;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [ADDR_W-1:0] address;
        logic [PLEN_W-1:0] prefix_length;
        logic [HOP_W-1:0]  route_next_hop;
        logic [IFC_W-1:0]  route_interface;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic             table_full;
        logic [HOP_W-1:0] match_next_hop;
        logic [IFC_W-1:0] match_interface;
    } t_out_item;

endpackage

`default_nettype wire

// File: rtl/core/blpm_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module blpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/core/blpm_engine.sv
// trie walk engine with child link and route memories
`default_nettype none

`include "assert_macros.svh"

module blpm_engine import blpm_pkg::*; #(
    parameter int NODE_POOL_SIZE = NODE_POOL_SIZE_DEF,
    parameter int INTERFACE_BITS = INTERFACE_BITS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_res_valid,
    input  wire logic      i_res_ready,
    output t_out_item      o_res_data
);

    localparam int NB     = $clog2(NODE_POOL_SIZE);
    localparam int FREE_W = NB + 1;
    localparam int LINK_W = 2 * NB;
    localparam int IFW    = INTERFACE_BITS;
    localparam int RT_W   = 1 + HOP_W + IFW;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_WALK,
        S_FIN
    } t_state;

    t_state              r_state, n_state;
    logic                r_op, n_op;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [PLEN_W-1:0]   r_plen, n_plen;
    logic [HOP_W-1:0]    r_hop, n_hop;
    logic [IFW-1:0]      r_ifc, n_ifc;
    logic [PLEN_W-1:0]   r_lvl, n_lvl;
    logic [NB-1:0]       r_node, n_node;
    logic                r_fresh, n_fresh;
    logic [FREE_W-1:0]   r_free, n_free;
    t_out_item           r_res, n_res;

    logic                link_we, link_re;
    logic [NB-1:0]       link_waddr, link_raddr;
    logic [LINK_W-1:0]   link_wdata, link_rdata;
    logic                rt_we, rt_re;
    logic [NB-1:0]       rt_waddr, rt_raddr;
    logic [RT_W-1:0]     rt_wdata, rt_rdata;

    blpm_ram #(.WIDTH(LINK_W), .DEPTH(NODE_POOL_SIZE)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (link_re),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    blpm_ram #(.WIDTH(RT_W), .DEPTH(NODE_POOL_SIZE)) u_route_ram (
        .i_clk   (i_clk),
        .i_we    (rt_we),
        .i_waddr (rt_waddr),
        .i_wdata (rt_wdata),
        .i_re    (rt_re),
        .i_raddr (rt_raddr),
        .o_rdata (rt_rdata)
    );

    always_comb begin
        logic [LINK_W-1:0] links;
        logic              side;
        logic [NB-1:0]     child;
        logic [NB-1:0]     fresh_node;

        n_state    = r_state;
        n_op       = r_op;
        n_addr     = r_addr;
        n_plen     = r_plen;
        n_hop      = r_hop;
        n_ifc      = r_ifc;
        n_lvl      = r_lvl;
        n_node     = r_node;
        n_fresh    = r_fresh;
        n_free     = r_free;
        n_res      = r_res;
        link_we    = 1'b0;
        link_re    = 1'b0;
        link_waddr = r_node;
        link_raddr = '0;
        link_wdata = '0;
        rt_we      = 1'b0;
        rt_re      = 1'b0;
        rt_waddr   = r_node;
        rt_raddr   = '0;
        rt_wdata   = '0;
        o_in_ready = 1'b0;
        o_res_valid = 1'b0;

        links      = r_fresh ? '0 : link_rdata;
        side       = r_addr[TOP_BIT];
        child      = side ? links[LINK_W-1:NB] : links[NB-1:0];
        fresh_node = r_free[NB-1:0];

        unique case (r_state)
            S_INIT: begin
                // root starts with no children and no route
                link_we    = 1'b1;
                link_waddr = '0;
                rt_we      = 1'b1;
                rt_waddr   = '0;
                n_state    = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_op    = i_in_data.operation;
                    n_addr  = i_in_data.address;
                    n_plen  = (i_in_data.prefix_length > PLEN_W'(ADDR_W)) ?
                              PLEN_W'(ADDR_W) : i_in_data.prefix_length;
                    n_hop   = i_in_data.route_next_hop;
                    n_ifc   = IFW'(i_in_data.route_interface);
                    n_lvl   = '0;
                    n_node  = '0;
                    n_fresh = 1'b0;
                    n_res   = '0;
                    link_re = 1'b1;
                    rt_re   = 1'b1;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (r_op == OP_LOOKUP) begin
                    if (rt_rdata[RT_W-1]) begin
                        n_res.found           = 1'b1;
                        n_res.match_next_hop  = rt_rdata[IFW +: HOP_W];
                        n_res.match_interface = IFC_W'(rt_rdata[IFW-1:0]);
                    end
                    if (r_lvl == PLEN_W'(ADDR_W) || child == '0) begin
                        n_state = S_FIN;
                    end else begin
                        link_re    = 1'b1;
                        link_raddr = child;
                        rt_re      = 1'b1;
                        rt_raddr   = child;
                        n_node     = child;
                        n_lvl      = r_lvl + 1'b1;
                        n_addr     = r_addr << 1;
                    end
                end else if (r_lvl == r_plen) begin
                    rt_we    = 1'b1;
                    rt_wdata = {1'b1, r_hop, r_ifc};
                    link_we  = r_fresh;
                    n_state  = S_FIN;
                end else if (child != '0) begin
                    link_re    = 1'b1;
                    link_raddr = child;
                    n_node     = child;
                    n_lvl      = r_lvl + 1'b1;
                    n_addr     = r_addr << 1;
                    n_fresh    = 1'b0;
                end else if (r_free >= FREE_W'(NODE_POOL_SIZE)) begin
                    n_res.table_full = 1'b1;
                    link_we          = r_fresh;
                    n_state          = S_FIN;
                end else begin
                    // take a node from the pool and hang it on the walk side
                    link_we    = 1'b1;
                    link_wdata = side ? {fresh_node, links[NB-1:0]} :
                                        {links[LINK_W-1:NB], fresh_node};
                    rt_we      = 1'b1;
                    rt_waddr   = fresh_node;
                    n_free     = r_free + 1'b1;
                    n_node     = fresh_node;
                    n_fresh    = 1'b1;
                    n_lvl      = r_lvl + 1'b1;
                    n_addr     = r_addr << 1;
                end
            end
            S_FIN: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_free  <= FREE_W'(1);
        end else begin
            r_state <= n_state;
            r_free  <= n_free;
        end
        r_op    <= n_op;
        r_addr  <= n_addr;
        r_plen  <= n_plen;
        r_hop   <= n_hop;
        r_ifc   <= n_ifc;
        r_lvl   <= n_lvl;
        r_node  <= n_node;
        r_fresh <= n_fresh;
        r_res   <= n_res;
    end

    assign o_res_data = r_res;

    `BLPM_ASSERT_IMP(a_free_bound, i_clk, i_rst_n, 1'b1, r_free <= FREE_W'(NODE_POOL_SIZE))
    `BLPM_ASSERT_NEXT(a_free_hold, i_clk, i_rst_n, r_state != S_WALK, $stable(r_free))
    `BLPM_ASSERT_IMP(a_lvl_bound, i_clk, i_rst_n, r_state == S_WALK, r_lvl <= PLEN_W'(ADDR_W))
    `BLPM_ASSERT_IMP(a_fresh_insert, i_clk, i_rst_n, r_state == S_WALK && r_fresh, r_op == OP_INSERT)

endmodule

`default_nettype wire

// File: rtl/core/binary_trie_longest_prefix_match.sv
// top level of the binary trie longest prefix match route table
//
//   channel   direction   handshake                      payload
//   in        input       i_in_valid / o_in_ready        i_in_data  (t_in_item)
//   out       output      o_out_valid / i_out_ready      o_out_data (t_out_item)
//
// a beat is accepted in S_IDLE, then walks the trie level by level in S_WALK,
// and ends in S_FIN, where the engine offers its result to the output register
// each trie level waits on the registered read of the child link memory
// after reset the S_INIT state writes the root entries, o_in_ready stays low meanwhile
// the output register holds a result while the next beat is accepted
// a finished result waits in the engine while the output register is full
`default_nettype none

module binary_trie_longest_prefix_match import blpm_pkg::*; #(
    parameter int NODE_POOL_SIZE = NODE_POOL_SIZE_DEF,
    parameter int INTERFACE_BITS = INTERFACE_BITS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    logic      res_valid;
    logic      slot_free;
    t_out_item res_data;
    logic      r_out_valid;
    t_out_item r_out;

    assign slot_free = !r_out_valid || i_out_ready;

    blpm_engine #(
        .NODE_POOL_SIZE (NODE_POOL_SIZE),
        .INTERFACE_BITS (INTERFACE_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_res_valid (res_valid),
        .i_res_ready (slot_free),
        .o_res_data  (res_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot_free) begin
            r_out_valid <= res_valid;
        end
        if (slot_free && res_valid) begin
            r_out <= res_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// File: sim/binary_trie_longest_prefix_match_tb.sv
// testbench for the binary trie longest prefix match route table
module binary_trie_longest_prefix_match_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import blpm_pkg::*;

    localparam int unsigned POOL         = NODE_POOL_SIZE_DEF;
    localparam int unsigned RANDOM_BEATS = 1750;
    localparam logic [IFC_W-1:0] IFC_KEEP = IFC_W'((1 << INTERFACE_BITS_DEF) - 1);

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    binary_trie_longest_prefix_match u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // trie shadow
    int unsigned    trie_left  [POOL];
    int unsigned    trie_right [POOL];
    bit             node_has_route [POOL];
    logic [HOP_W-1:0] node_hop [POOL];
    logic [IFC_W-1:0] node_ifc [POOL];
    int unsigned    nodes_taken = 1;

    t_in_item          pending_beats [$];
    t_out_item         route_results [$];
    logic [ADDR_W-1:0] known_addr [$];
    int unsigned       known_len  [$];

    int unsigned total_beats  = 0;
    int unsigned beats_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned inserts_sent = 0;
    int unsigned lookups_sent = 0;
    int unsigned hits         = 0;
    int unsigned full_inserts = 0;
    int unsigned mismatches   = 0;

    int unsigned burst_left = 8;
    int unsigned gap_left   = 0;
    int unsigned stall_left = 0;
    int unsigned rx_cycle   = 0;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic t_out_item predict_route(input t_in_item beat);
        t_out_item   res;
        int unsigned plen;
        int unsigned node;
        int unsigned nxt;
        int unsigned lvl;
        logic        side;
        logic        overflow;
        res      = '0;
        node     = 0;
        overflow = 1'b0;
        if (beat.operation == OP_INSERT) begin
            plen = (beat.prefix_length > ADDR_W) ? ADDR_W : beat.prefix_length;
            for (lvl = 0; lvl < plen && !overflow; lvl++) begin
                side = beat.address[TOP_BIT - lvl];
                nxt  = side ? trie_right[node] : trie_left[node];
                if (nxt == 0) begin
                    if (nodes_taken >= POOL) begin
                        overflow = 1'b1;
                    end else begin
                        nxt = nodes_taken;
                        nodes_taken++;
                        trie_left[nxt]      = 0;
                        trie_right[nxt]     = 0;
                        node_has_route[nxt] = 1'b0;
                        if (side) begin
                            trie_right[node] = nxt;
                        end else begin
                            trie_left[node] = nxt;
                        end
                    end
                end
                node = nxt;
            end
            if (overflow) begin
                res.table_full = 1'b1;
            end else begin
                node_has_route[node] = 1'b1;
                node_hop[node]       = beat.route_next_hop;
                node_ifc[node]       = beat.route_interface & IFC_KEEP;
            end
        end else begin
            if (node_has_route[0]) begin
                res.found           = 1'b1;
                res.match_next_hop  = node_hop[0];
                res.match_interface = node_ifc[0];
            end
            for (lvl = 0; lvl < ADDR_W; lvl++) begin
                side = beat.address[TOP_BIT - lvl];
                node = side ? trie_right[node] : trie_left[node];
                if (node == 0) break;
                if (node_has_route[node]) begin
                    res.found           = 1'b1;
                    res.match_next_hop  = node_hop[node];
                    res.match_interface = node_ifc[node];
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch %s: got %h want %h at %0t ns", what, got, want, $time);
    endtask

    function automatic void add_beat(input logic op, input logic [ADDR_W-1:0] addr,
                                     input int unsigned plen, input logic [HOP_W-1:0] hop,
                                     input logic [IFC_W-1:0] ifc);
        t_in_item beat;
        beat.operation       = op;
        beat.address         = addr;
        beat.prefix_length   = PLEN_W'(plen);
        beat.route_next_hop  = hop;
        beat.route_interface = ifc;
        pending_beats.push_back(beat);
        if (op == OP_INSERT) begin
            known_addr.push_back(addr);
            known_len.push_back((plen > ADDR_W) ? ADDR_W : plen);
        end
    endfunction

    function automatic logic [ADDR_W-1:0] with_random_tail(input logic [ADDR_W-1:0] base,
                                                           input int unsigned len);
        logic [ADDR_W-1:0] keep;
        keep = (len == 0) ? '0 : ({ADDR_W{1'b1}} << (ADDR_W - len));
        return (base & keep) | (ADDR_W'($urandom()) & ~keep);
    endfunction

    // sender: bursts of beats with random gaps, prediction at acceptance
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                route_results.push_back(predict_route(in_data));
                beats_sent++;
                if (in_data.operation == OP_INSERT) begin
                    inserts_sent++;
                end else begin
                    lookups_sent++;
                end
            end
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    in_valid <= 1'b1;
                    in_data  <= pending_beats.pop_front();
                    burst_left = burst_left - 1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 20);
                        gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each beat, cycling through four stall patterns
    always @(posedge clk) begin
        t_out_item want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            rx_cycle++;
            if (out_valid && out_ready) begin
                results_seen++;
                if (route_results.size() == 0) begin
                    report_mismatch("unexpected result beat", out_data.match_next_hop, '0);
                end else begin
                    want = route_results.pop_front();
                    if (out_data.found !== want.found)
                        report_mismatch("found", 32'(out_data.found), 32'(want.found));
                    if (out_data.table_full !== want.table_full)
                        report_mismatch("table_full", 32'(out_data.table_full),
                                        32'(want.table_full));
                    if (out_data.match_next_hop !== want.match_next_hop)
                        report_mismatch("match_next_hop", out_data.match_next_hop,
                                        want.match_next_hop);
                    if (out_data.match_interface !== want.match_interface)
                        report_mismatch("match_interface", 32'(out_data.match_interface),
                                        32'(want.match_interface));
                    if (want.found) hits++;
                    if (want.table_full) full_inserts++;
                end
            end
            case ((rx_cycle / 300) % 4)
                0: begin
                    out_ready <= 1'b1;
                end
                1: begin
                    out_ready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    if (stall_left > 0) begin
                        stall_left = stall_left - 1;
                        out_ready <= 1'b0;
                    end else begin
                        out_ready <= 1'b1;
                        if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 16);
                    end
                end
                default: begin
                    out_ready <= ($urandom_range(0, 7) != 0);
                end
            endcase
        end
    end

    initial begin
        int unsigned       n;
        int unsigned       pick;
        int unsigned       sel;
        int unsigned       idx;
        int unsigned       plen;
        int unsigned       base_len;
        logic [ADDR_W-1:0] base_addr;

        // directed beats
        add_beat(OP_LOOKUP, 32'h0000_0000, 0, '0, '0);
        add_beat(OP_LOOKUP, 32'hFFFF_FFFF, 63, '1, '1);
        add_beat(OP_INSERT, 32'h0000_0000, 0, 32'h0101_0101, 8'h01);
        add_beat(OP_LOOKUP, 32'hDEAD_BEEF, 0, '0, '0);
        add_beat(OP_INSERT, 32'hFFFF_FFFF, 32, 32'hFFFF_FFFF, 8'hFF);
        add_beat(OP_LOOKUP, 32'hFFFF_FFFF, 0, '0, '0);
        add_beat(OP_LOOKUP, 32'hFFFF_FFFE, 0, '0, '0);
        add_beat(OP_INSERT, 32'h0000_0000, 63, 32'h0000_0000, 8'h00);
        add_beat(OP_LOOKUP, 32'h0000_0000, 0, '0, '0);
        add_beat(OP_INSERT, 32'h8000_0000, 1, 32'h0A0A_0A0A, 8'h02);
        add_beat(OP_LOOKUP, 32'hC000_0000, 0, '0, '0);
        add_beat(OP_INSERT, 32'h8000_0000, 1, 32'h0B0B_0B0B, 8'h03);
        add_beat(OP_LOOKUP, 32'h8000_0001, 0, '0, '0);
        add_beat(OP_INSERT, 32'hC0A8_0000, 16, 32'hC0A8_0001, 8'h04);
        add_beat(OP_INSERT, 32'hC0A8_0100, 24, 32'hC0A8_0101, 8'h05);
        add_beat(OP_LOOKUP, 32'hC0A8_0105, 0, '0, '0);
        add_beat(OP_LOOKUP, 32'hC0A8_0205, 0, '0, '0);
        add_beat(OP_LOOKUP, 32'hC0A7_FFFF, 0, '0, '0);
        add_beat(OP_INSERT, 32'h0A00_0000, 33, 32'h0A00_00FE, 8'h80);
        add_beat(OP_LOOKUP, 32'h0A00_0000, 0, '0, '0);
        add_beat(OP_LOOKUP, 32'h0A00_0001, 0, '0, '0);
        add_beat(OP_INSERT, 32'h5555_5555, 32, 32'hAAAA_AAAA, 8'h7F);
        add_beat(OP_LOOKUP, 32'h5555_5555, 0, '0, '0);

        // random beats, mostly built around prefixes already inserted
        for (n = 0; n < RANDOM_BEATS; n++) begin
            pick      = $urandom_range(0, 99);
            idx       = $urandom_range(0, known_addr.size() - 1);
            base_addr = known_addr[idx];
            base_len  = known_len[idx];
            if (pick < 35) begin
                add_beat(OP_LOOKUP, with_random_tail(base_addr, base_len),
                         $urandom_range(0, 63), $urandom(),
                         IFC_W'($urandom_range(0, 255)));
            end else if (pick < 45) begin
                add_beat(OP_LOOKUP, $urandom(), $urandom_range(0, 63), $urandom(),
                         IFC_W'($urandom_range(0, 255)));
            end else if (pick < 55) begin
                add_beat(OP_INSERT, with_random_tail(base_addr, base_len), base_len,
                         $urandom(), IFC_W'($urandom_range(0, 255)));
            end else if (pick < 75) begin
                plen = base_len + $urandom_range(1, 8);
                if (plen > ADDR_W) plen = $urandom_range(ADDR_W, 63);
                add_beat(OP_INSERT, with_random_tail(base_addr, base_len), plen,
                         $urandom(), IFC_W'($urandom_range(0, 255)));
            end else begin
                sel  = $urandom_range(0, 9);
                plen = (sel < 4) ? $urandom_range(0, 16) :
                       (sel < 7) ? $urandom_range(17, 24) :
                       (sel < 9) ? $urandom_range(25, 32) : $urandom_range(33, 63);
                add_beat(OP_INSERT, $urandom(), plen, $urandom(),
                         IFC_W'($urandom_range(0, 255)));
            end
        end
        total_beats = pending_beats.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (beats_sent < total_beats || route_results.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);

        $display("ran %0d inserts (%0d hit a full pool) and %0d lookups (%0d matched)",
                 inserts_sent, full_inserts, lookups_sent, hits);
        $display("trie grew to %0d of %0d nodes, %0d result beats checked, %0d mismatches",
                 nodes_taken, POOL, results_seen, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout with %0d of %0d beats sent", beats_sent, total_beats);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
